// ===== src/lqe_pkg.sv =====
`timescale 1ns / 1ps
package lqe_pkg;

	localparam int LW_W   = 23;
	localparam logic [LW_W-1:0] LW_RESET = 23'd65536;

	// normalised magnitude width, squares and root
	localparam int NORM_W = 31;
	localparam int PROD_W = 2 * NORM_W;
	localparam int SQ_W   = 64;
	localparam int ROOT_W = 32;
	// 800 * root
	localparam int DEN_W  = 42;
	// offset magnitude is at most line_width / 800 rounded
	localparam int QW     = 14;
	localparam int REM_W  = DEN_W + QW - 1;
	// signed offset sums (two magnitudes plus sign)
	localparam int OFF_W  = 16;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] qa;
		logic [QW-1:0] qb;
	} off_res_t;

endpackage

// ===== src/lqe_offset_unit.sv =====
`timescale 1ns / 1ps
module lqe_offset_unit #(
	parameter int CW = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [CW-1:0]            mag_x,
	input  logic [CW-1:0]            mag_y,
	input  logic [lqe_pkg::LW_W-1:0] line_width,
	output lqe_pkg::off_res_t        res
);
	import lqe_pkg::*;

	localparam int MW = (CW > NORM_W) ? CW : NORM_W;

	localparam logic [3:0] U_IDLE = 4'd0;
	localparam logic [3:0] U_NORM = 4'd1;
	localparam logic [3:0] U_SQA  = 4'd2;
	localparam logic [3:0] U_SQB  = 4'd3;
	localparam logic [3:0] U_SUM  = 4'd4;
	localparam logic [3:0] U_SQRT = 4'd5;
	localparam logic [3:0] U_DEN  = 4'd6;
	localparam logic [3:0] U_MUL  = 4'd7;
	localparam logic [3:0] U_RND  = 4'd8;
	localparam logic [3:0] U_DIV  = 4'd9;

	logic [3:0]        st_q;
	logic [MW-1:0]     a_q, b_q;
	logic [MW-1:0]     ab_or;
	logic              too_big, too_small;
	logic [NORM_W-1:0] mul_x, mul_y;
	logic [PROD_W-1:0] prod_q;
	logic [SQ_W-1:0]   n_q, res_q, one_q, trial;
	logic [DEN_W-1:0]  den_q, root_ext;
	logic [REM_W-1:0]  rem_q, dcur_q;
	logic [QW-1:0]     quo_q, qa_q, qb_q;
	logic              qbit;
	logic              sel_q;
	logic [4:0]        cnt_q;
	logic              done_q;

	assign ab_or     = a_q | b_q;
	assign too_big   = |(ab_or >> NORM_W);
	assign too_small = (ab_or >> (NORM_W - 1)) == '0;

	// shared multiplier operand select
	always_comb begin
		mul_x = a_q[NORM_W-1:0];
		mul_y = a_q[NORM_W-1:0];
		case (st_q)
			U_SQB: begin
				mul_x = b_q[NORM_W-1:0];
				mul_y = b_q[NORM_W-1:0];
			end
			U_MUL: begin
				mul_x = sel_q ? b_q[NORM_W-1:0] : a_q[NORM_W-1:0];
				mul_y = NORM_W'(line_width);
			end
			default: begin
			end
		endcase
	end

	assign trial    = res_q + one_q;
	assign root_ext = DEN_W'(res_q[ROOT_W-1:0]);
	assign qbit     = rem_q >= dcur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			done_q <= 1'b0;
			sel_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				U_IDLE: begin
					if (start) begin
						st_q <= U_NORM;
					end
				end
				U_NORM: begin
					if (!too_big && !too_small) begin
						st_q <= U_SQA;
					end
				end
				U_SQA: st_q <= U_SQB;
				U_SQB: st_q <= U_SUM;
				U_SUM: begin
					st_q  <= U_SQRT;
					cnt_q <= '0;
				end
				U_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						st_q <= U_DEN;
					end
				end
				U_DEN: begin
					st_q  <= U_MUL;
					sel_q <= 1'b0;
				end
				U_MUL: st_q <= U_RND;
				U_RND: begin
					st_q  <= U_DIV;
					cnt_q <= '0;
				end
				U_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QW - 1)) begin
						if (sel_q) begin
							st_q   <= U_IDLE;
							done_q <= 1'b1;
						end else begin
							sel_q <= 1'b1;
							st_q  <= U_MUL;
						end
					end
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			U_IDLE: begin
				a_q <= MW'(mag_x);
				b_q <= MW'(mag_y);
			end
			U_NORM: begin
				if (too_big) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
				end else if (too_small) begin
					a_q <= a_q << 1;
					b_q <= b_q << 1;
				end
			end
			U_SQA: prod_q <= mul_x * mul_y;
			U_SQB: begin
				n_q    <= SQ_W'(prod_q);
				prod_q <= mul_x * mul_y;
			end
			U_SUM: begin
				n_q   <= n_q + SQ_W'(prod_q);
				res_q <= '0;
				one_q <= SQ_W'(1) << 62;
			end
			U_SQRT: begin
				if (n_q >= trial) begin
					n_q   <= n_q - trial;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
			end
			U_DEN: den_q <= (root_ext << 9) + (root_ext << 8) + (root_ext << 5);
			U_MUL: prod_q <= mul_x * mul_y;
			U_RND: begin
				rem_q  <= REM_W'(prod_q) + REM_W'(den_q >> 1);
				dcur_q <= REM_W'(den_q) << (QW - 1);
				quo_q  <= '0;
			end
			U_DIV: begin
				if (qbit) begin
					rem_q <= rem_q - dcur_q;
				end
				dcur_q <= dcur_q >> 1;
				quo_q  <= {quo_q[QW-2:0], qbit};
				if (cnt_q == 5'(QW - 1)) begin
					if (sel_q) begin
						qb_q <= {quo_q[QW-2:0], qbit};
					end else begin
						qa_q <= {quo_q[QW-2:0], qbit};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res.done = done_q;
	assign res.qa   = qa_q;
	assign res.qb   = qb_q;

endmodule

// ===== src/lqe_vertex_out.sv =====
`timescale 1ns / 1ps
module lqe_vertex_out #(
	parameter int CW = 32,
	parameter int IW = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [CW-1:0]                    base_x,
	input  logic [CW-1:0]                    base_y,
	input  logic signed [lqe_pkg::OFF_W-1:0] off_x,
	input  logic signed [lqe_pkg::OFF_W-1:0] off_y,
	input  logic [IW-1:0]                    index,
	input  logic                             degen,
	input  logic                             last,
	output logic                             ready,
	output logic                             vertex_valid,
	input  logic                             vertex_stall,
	output logic [CW-1:0]                    vertex_x,
	output logic [CW-1:0]                    vertex_y,
	output logic [IW-1:0]                    vertex_number,
	output logic                             degenerate,
	output logic                             last_of_quad
);
	import lqe_pkg::*;

	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [CW:0] sx, sy;
	logic [CW-1:0]      satx, saty;
	logic               valid_q;

	assign sx = $signed({base_x[CW-1], base_x}) + (CW+1)'(off_x);
	assign sy = $signed({base_y[CW-1], base_y}) + (CW+1)'(off_y);

	// clamp on overflow of the signed range
	assign satx = (sx[CW] != sx[CW-1]) ? (sx[CW] ? CMIN : CMAX) : sx[CW-1:0];
	assign saty = (sy[CW] != sy[CW-1]) ? (sy[CW] ? CMIN : CMAX) : sy[CW-1:0];

	assign ready        = !valid_q || !vertex_stall;
	assign vertex_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!vertex_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			vertex_x      <= satx;
			vertex_y      <= saty;
			vertex_number <= index;
			degenerate    <= degen;
			last_of_quad  <= last;
		end
	end

endmodule

// ===== src/wide_line_quad_expander.sv =====
`timescale 1ns / 1ps
// channel    signals                                         transaction
// point      point_valid point_stall point_x point_y         one polyline point
//            starts_run ends_run
// vertex     vertex_valid vertex_stall vertex_x vertex_y     one quad vertex
//            vertex_number degenerate last_of_quad
// cfg        cfg_valid cfg_ready line_width                  line width write
//
// a point that only gets stored is taken without a stall; a zero-length segment
// skips the offset unit and takes four vertex slots
// a normal segment runs through the shared offset unit: normalise, the squares
// and their sum, the root, 800*root and the two rounding divides, then four
// vertex slots
// asynchronous reset clears the stored point and the vertex index and sets the width to LW_RESET
// point_stall is high from acceptance of a segment until its last vertex has
// entered the output register; vertex_stall holds that register and the vertex emission
module wide_line_quad_expander #(
	parameter int COORD_WIDTH = 32,
	parameter int INDEX_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [lqe_pkg::LW_W-1:0] line_width,
	input  logic                     point_valid,
	output logic                     point_stall,
	input  logic [COORD_WIDTH-1:0]   point_x,
	input  logic [COORD_WIDTH-1:0]   point_y,
	input  logic                     starts_run,
	input  logic                     ends_run,
	output logic                     vertex_valid,
	input  logic                     vertex_stall,
	output logic [COORD_WIDTH-1:0]   vertex_x,
	output logic [COORD_WIDTH-1:0]   vertex_y,
	output logic [INDEX_WIDTH-1:0]   vertex_number,
	output logic                     degenerate,
	output logic                     last_of_quad
);
	import lqe_pkg::*;

	localparam int CW = COORD_WIDTH;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]             state_q;
	logic [1:0]             k_q;
	logic [LW_W-1:0]        lw_q;
	logic [CW-1:0]          prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic                   have_prev_q, end_q, nx_q, ny_q, degen_q;
	logic [INDEX_WIDTH-1:0] counter_q;
	logic signed [OFF_W-1:0] ox_q, oy_q, px_q, py_q;

	logic                   accept, store_only;
	logic signed [CW:0]     dx, dy;
	logic [CW-1:0]          mag_x, mag_y;
	logic                   unit_start;
	off_res_t               unit_res;
	logic signed [OFF_W-1:0] qa_s, qb_s;

	logic                   out_ready, push;
	logic [CW-1:0]          base_x, base_y;
	logic signed [OFF_W-1:0] off_x, off_y;

	assign cfg_ready   = 1'b1;
	assign point_stall = state_q != ST_IDLE;
	assign accept      = point_valid && !point_stall;
	assign store_only  = starts_run || !have_prev_q;

	// segment vector from the stored point, as sign and magnitude
	assign dx    = $signed({point_x[CW-1], point_x}) - $signed({prev_x_q[CW-1], prev_x_q});
	assign dy    = $signed({point_y[CW-1], point_y}) - $signed({prev_y_q[CW-1], prev_y_q});
	assign mag_x = dx[CW] ? CW'(-dx) : dx[CW-1:0];
	assign mag_y = dy[CW] ? CW'(-dy) : dy[CW-1:0];

	assign unit_start = accept && !store_only && (mag_x != '0 || mag_y != '0);

	lqe_offset_unit #(
		.CW(CW)
	) u_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (unit_start),
		.mag_x     (mag_x),
		.mag_y     (mag_y),
		.line_width(lw_q),
		.res       (unit_res)
	);

	assign qa_s = OFF_W'(unit_res.qa);
	assign qb_s = OFF_W'(unit_res.qb);

	// v0 = p1 + o, v1 = p1 - o, v2 = p2 + o + d, v3 = p2 - o + d
	always_comb begin
		base_x = prev_x_q;
		base_y = prev_y_q;
		off_x  = ox_q;
		off_y  = oy_q;
		case (k_q)
			2'd1: begin
				off_x = -ox_q;
				off_y = -oy_q;
			end
			2'd2: begin
				base_x = cur_x_q;
				base_y = cur_y_q;
				off_x  = ox_q + px_q;
				off_y  = oy_q + py_q;
			end
			2'd3: begin
				base_x = cur_x_q;
				base_y = cur_y_q;
				off_x  = px_q - ox_q;
				off_y  = py_q - oy_q;
			end
			default: begin
			end
		endcase
	end

	assign push = (state_q == ST_EMIT) && out_ready;

	lqe_vertex_out #(
		.CW(CW),
		.IW(INDEX_WIDTH)
	) u_vertex (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.base_x       (base_x),
		.base_y       (base_y),
		.off_x        (off_x),
		.off_y        (off_y),
		.index        (counter_q),
		.degen        (degen_q),
		.last         (k_q == 2'd3),
		.ready        (out_ready),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_number(vertex_number),
		.degenerate   (degenerate),
		.last_of_quad (last_of_quad)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			lw_q        <= LW_RESET;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			counter_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				lw_q <= line_width;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (store_only) begin
							prev_x_q    <= point_x;
							prev_y_q    <= point_y;
							have_prev_q <= 1'b1;
						end else if (unit_start) begin
							state_q <= ST_WAIT;
						end else begin
							state_q <= ST_EMIT;
							k_q     <= '0;
						end
					end
				end
				ST_WAIT: begin
					if (unit_res.done) begin
						state_q <= ST_EMIT;
						k_q     <= '0;
					end
				end
				ST_EMIT: begin
					if (push) begin
						counter_q <= counter_q + 1'b1;
						k_q       <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							state_q     <= ST_IDLE;
							prev_x_q    <= cur_x_q;
							prev_y_q    <= cur_y_q;
							have_prev_q <= !end_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// segment payload and signed offsets
	always_ff @(posedge clk) begin
		if (accept && !store_only) begin
			cur_x_q <= point_x;
			cur_y_q <= point_y;
			end_q   <= ends_run;
			nx_q    <= dx[CW];
			ny_q    <= dy[CW];
			degen_q <= !unit_start;
			ox_q    <= '0;
			oy_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
		end else if (state_q == ST_WAIT && unit_res.done) begin
			ox_q <= ny_q ? -qb_s : qb_s;
			oy_q <= nx_q ? qa_s : -qa_s;
			px_q <= end_q ? '0 : (nx_q ? -qa_s : qa_s);
			py_q <= end_q ? '0 : (ny_q ? -qb_s : qb_s);
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import lqe_pkg::*;

	localparam int CW = 32;
	localparam int IW = 32;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [IW-1:0] num;
		logic          degen;
		logic          last;
	} vertex_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          st;
		logic          en;
		logic          has_exp;
		logic [CW-1:0] ex0;
		logic [CW-1:0] ey0;
	} row_t;

	typedef struct packed {
		logic [IW-1:0] num;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
	} typed_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [LW_W-1:0] line_width = '0;
	logic point_valid = 0;
	logic point_stall;
	logic [CW-1:0] point_x = '0;
	logic [CW-1:0] point_y = '0;
	logic starts_run = 0;
	logic ends_run = 0;
	logic vertex_valid;
	logic vertex_stall = 0;
	logic [CW-1:0] vertex_x;
	logic [CW-1:0] vertex_y;
	logic [IW-1:0] vertex_number;
	logic degenerate;
	logic last_of_quad;

	// predictor state
	logic [LW_W-1:0] width_q;
	logic signed [CW-1:0] stored_x, stored_y;
	logic have_stored;
	logic [IW-1:0] next_vertex;

	vertex_t pending_vertices[$];
	// first vertex of a typed directed row, checked against the block directly
	typed_t typed_first[$];
	int errors = 0;
	bit stall_busy = 0;

	always #4 clk = ~clk;

	wide_line_quad_expander u_dut (.*);

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [63:0] root64(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint offset_of(input logic [63:0] m, input logic [63:0] den,
			input bit neg);
		logic [63:0] q;
		q = (m * width_q + den / 2) / den;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [CW-1:0] sat_sum(input longint c, input longint d);
		longint s;
		s = c + d;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[CW-1:0];
	endfunction

	function automatic void push_vertex(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input bit dg, input bit lst);
		vertex_t v;
		v.x = x; v.y = y; v.num = next_vertex; v.degen = dg; v.last = lst;
		pending_vertices.push_back(v);
		next_vertex++;
	endfunction

	// point storage, or segment expansion into four quad vertices
	function automatic void expand_point(input logic [CW-1:0] px_in, input logic [CW-1:0] py_in,
			input bit st, input bit en);
		longint x, y, p1x, p1y, ox, oy, fx, fy;
		logic [63:0] ax, ay, mx, den;
		bit nx, ny, dg;
		x = longint'(signed'(px_in));
		y = longint'(signed'(py_in));
		if (st || !have_stored) begin
			stored_x = px_in; stored_y = py_in; have_stored = 1;
			return;
		end
		p1x = longint'(stored_x);
		p1y = longint'(stored_y);
		nx = x < p1x; ny = y < p1y;
		ax = nx ? p1x - x : x - p1x;
		ay = ny ? p1y - y : y - p1y;
		dg = (ax == 0 && ay == 0);
		ox = 0; oy = 0; fx = 0; fy = 0;
		if (!dg) begin
			mx = ax > ay ? ax : ay;
			while (mx >= 64'd1 << 31) begin mx >>= 1; ax >>= 1; ay >>= 1; end
			while (mx < 64'd1 << 30) begin mx <<= 1; ax <<= 1; ay <<= 1; end
			den = 800 * root64(ax * ax + ay * ay);
			ox = offset_of(ay, den, ny);
			oy = offset_of(ax, den, !nx);
			if (!en) begin
				fx = offset_of(ax, den, nx);
				fy = offset_of(ay, den, ny);
			end
		end
		push_vertex(sat_sum(p1x, ox), sat_sum(p1y, oy), dg, 0);
		push_vertex(sat_sum(p1x, -ox), sat_sum(p1y, -oy), dg, 0);
		push_vertex(sat_sum(x, ox + fx), sat_sum(y, oy + fy), dg, 0);
		push_vertex(sat_sum(x, fx - ox), sat_sum(y, fy - oy), dg, 1);
		stored_x = px_in; stored_y = py_in; have_stored = !en;
	endfunction

	// vertex checking
	always @(posedge clk) begin
		vertex_t want;
		typed_t tt;
		if (vertex_valid && !vertex_stall) begin
			if (pending_vertices.size() == 0) begin
				report("unexpected vertex", vertex_number, 0);
			end else begin
				want = pending_vertices.pop_front();
				if (vertex_x !== want.x) report("vertex_x", vertex_x, want.x);
				if (vertex_y !== want.y) report("vertex_y", vertex_y, want.y);
				if (vertex_number !== want.num) report("vertex_number", vertex_number, want.num);
				if (degenerate !== want.degen) report("degenerate", degenerate, want.degen);
				if (last_of_quad !== want.last) report("last_of_quad", last_of_quad, want.last);
				if (typed_first.size() > 0 && typed_first[0].num == want.num) begin
					tt = typed_first.pop_front();
					if (vertex_x !== tt.x) report("typed vertex_x", vertex_x, tt.x);
					if (vertex_y !== tt.y) report("typed vertex_y", vertex_y, tt.y);
					if (degenerate !== 1'b1) report("typed degenerate", degenerate, 1);
				end
			end
		end
	end

	// receiver stall pattern: busy windows with heavy stalling, quiet windows with rare stalls
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_busy) vertex_stall <= (r < 45);
		else vertex_stall <= (r < 3);
		if ($urandom_range(0, 49) == 0) stall_busy <= ~stall_busy;
	end

	task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input bit st, input bit en);
		point_x <= x; point_y <= y; starts_run <= st; ends_run <= en;
		point_valid <= 1;
		@(posedge clk);
		while (point_stall) @(posedge clk);
		expand_point(x, y, st, en);
	endtask

	task automatic idle_gap(input int n);
		point_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		point_valid <= 0;
		while (pending_vertices.size() != 0) @(posedge clk);
		// let any segment still in flight settle
		repeat (150) @(posedge clk);
	endtask

	task automatic write_width(input logic [LW_W-1:0] w);
		drain();
		cfg_valid <= 1;
		line_width <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		width_q = w;
	endtask

	function automatic logic [CW-1:0] rnd_coord(input int style);
		case (style)
			0: return $urandom();
			1: return 32'($urandom_range(0, 4000)) - 32'd2000;
			2: return ($urandom_range(0, 1) ? 32'h7fff0000 : 32'h80010000) + $urandom_range(0, 65535);
			default: return ($urandom() & 32'h00ff_ffff) - 32'h0080_0000;
		endcase
	endfunction

	row_t dir_rows[$];

	initial begin
		int burst, style;
		logic [CW-1:0] x, y;
		bit st, en;
		row_t r;
		typed_t tv;
		width_q = LW_RESET;
		stored_x = 0; stored_y = 0; have_stored = 0; next_vertex = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: degenerate rows have fully known results
		dir_rows = '{
			'{32'h0001_0000, 32'h0002_0000, 1, 0, 0, 0, 0},
			'{32'h0001_0000, 32'h0002_0000, 0, 0, 1, 32'h0001_0000, 32'h0002_0000},
			'{32'h0005_0000, 32'h0002_0000, 0, 0, 0, 0, 0},
			'{32'h0005_0000, 32'h0009_0000, 0, 0, 0, 0, 0},
			'{32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0},
			'{32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0},
			'{32'h7fff_ffff, 32'h8000_0000, 0, 1, 0, 0, 0},
			'{32'h0000_0003, 32'h0000_0000, 0, 0, 0, 0, 0},
			'{32'h0000_0004, 32'h0000_0000, 0, 0, 0, 0, 0},
			'{32'h0000_0004, 32'hffff_ffff, 1, 1, 0, 0, 0},
			'{32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0, 0},
			'{32'hffff_0000, 32'h0001_0000, 0, 1, 0, 0, 0},
			'{32'h1234_5678, 32'hedcb_a987, 0, 0, 0, 0, 0},
			'{32'h1234_5678, 32'hedcb_a987, 0, 1, 1, 32'h1234_5678, 32'hedcb_a987},
			'{32'h7fff_0000, 32'h0000_0000, 1, 0, 0, 0, 0},
			'{32'h7fff_fff0, 32'h0000_0010, 0, 0, 0, 0, 0},
			'{32'h8000_0010, 32'h7fff_fff0, 0, 0, 0, 0, 0},
			'{32'h5555_5555, 32'haaaa_aaaa, 0, 1, 0, 0, 0}
		};
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			send_point(r.x, r.y, r.st, r.en);
			if (r.has_exp) begin
				// degenerate segment: the first vertex sits on the stored point
				if (pending_vertices.size() < 4) begin
					report("directed degenerate row", i, 0);
				end else begin
					tv.num = pending_vertices[$-3].num;
					tv.x   = r.ex0;
					tv.y   = r.ey0;
					typed_first.push_back(tv);
				end
			end
		end
		// every vertex has come before the sender goes on
		drain();

		write_width(23'h7f_ffff);
		send_point(32'h0, 32'h0, 1, 0);
		send_point(32'h0001_0000, 32'h0, 0, 0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 0, 1);
		write_width('0);
		send_point(32'h0, 32'h0, 1, 0);
		send_point(32'h0003_0000, 32'h0004_0000, 0, 1);
		write_width(23'd4194304);

		for (int n = 0; n < 220; ) begin
			if (n == 70) write_width(LW_W'($urandom_range(1, 23'h7f_ffff)));
			if (n == 150) write_width(LW_RESET);
			burst = $urandom_range(1, 12);
			style = $urandom_range(0, 3);
			send_point(rnd_coord(style), rnd_coord(style), 1, 0);
			n++;
			for (int k = 0; k < burst && n < 220; k++) begin
				x = rnd_coord(style);
				y = rnd_coord(style);
				if ($urandom_range(0, 9) == 0) begin x = stored_x; y = stored_y; end
				en = (k == burst - 1) ? $urandom_range(0, 3) != 0 : $urandom_range(0, 19) == 0;
				st = $urandom_range(0, 29) == 0;
				send_point(x, y, st, en);
				n++;
				if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 20));
			end
			if ($urandom_range(0, 1)) idle_gap($urandom_range(0, 40));
		end
		drain();
		if (errors == 0 && pending_vertices.size() == 0 && typed_first.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end

endmodule
